@@ rtl/lft_pkg.sv @@
// lft_pkg: shared types, constants and helpers for the login failure throttle
// depends on nothing; imported by every module of the block
`default_nettype none

package lft_pkg;

  // cache geometry
  localparam int CacheEntries = 3;
  localparam int IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

  // command codes
  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_INC   = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_LOCK  = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT_THRESHOLD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT_SECONDS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_WAIT_ENABLE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_WAIT_SECONDS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_SUPPRESS     = 3'd4;

  // register reset values
  localparam logic [3:0]  RST_LOCKOUT_THRESHOLD  = 4'd3;
  localparam logic [15:0] RST_LOCKOUT_SECONDS    = 16'd900;
  localparam logic        RST_SHORT_WAIT_ENABLE  = 1'b1;
  localparam logic [15:0] RST_SHORT_WAIT_SECONDS = 16'd15;
  localparam logic        RST_COUNT_SUPPRESS     = 1'b0;

  localparam logic [7:0] FAIL_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] client_ip;
    logic [63:0] account_key;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  lockout_threshold;
    logic [15:0] lockout_seconds;
    logic        short_wait_enable;
    logic [15:0] short_wait_seconds;
    logic        count_suppress;
  } cfg_t;

  // per-slot update strobes from the recency logic
  typedef struct packed {
    logic fill;
    logic bump;
    logic clear;
  } slot_ctl_t;

  // per-slot lookup report
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] status;
  } slot_rpt_t;

  // signed wrapping time difference inside a window; future times count as inside
  function automatic logic time_in_window(input logic [31:0] now, input logic [31:0] then,
                                          input logic [15:0] window);
    logic [31:0] d;
    d = now - then;
    return d[31] || (d <= {16'd0, window});
  endfunction

endpackage

`default_nettype wire

@@ rtl/lft_slot.sv @@
// lft_slot: one cache entry with its key compare, window test and update
// depends on lft_pkg
`default_nettype none

module lft_slot (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lft_pkg::req_t     req,
  input  wire lft_pkg::cfg_t     cfg,
  input  wire lft_pkg::slot_ctl_t ctl,
  output lft_pkg::slot_rpt_t     rpt
);
  import lft_pkg::*;

  logic        valid;
  logic [31:0] ip;
  logic [63:0] account;
  logic [7:0]  failures;
  logic [31:0] stamp;

  always_comb begin
    rpt.valid  = valid;
    rpt.hit    = valid && (ip == req.client_ip) && (account == req.account_key);
    rpt.status = STATUS_OK;
    if (failures >= {4'd0, cfg.lockout_threshold}) begin
      if (time_in_window(req.now_seconds, stamp, cfg.lockout_seconds)) begin
        rpt.status = STATUS_LOCK;
      end
    end else if ((failures != 8'd0) && cfg.short_wait_enable) begin
      if (time_in_window(req.now_seconds, stamp, cfg.short_wait_seconds)) begin
        rpt.status = STATUS_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.fill) begin
      valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      ip       <= req.client_ip;
      account  <= req.account_key;
      failures <= 8'd0;
      stamp    <= req.now_seconds;
    end else if (ctl.clear) begin
      failures <= 8'd0;
      stamp    <= req.now_seconds;
    end else if (ctl.bump) begin
      if (failures != FAIL_MAX) failures <= failures + 8'd1;
      stamp <= req.now_seconds;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lft_recency.sv @@
// lft_recency: recency order, hit and victim selection, per-slot update strobes
// depends on lft_pkg
`default_nettype none

module lft_recency (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [1:0]         cmd,
  input  wire logic               count_suppress,
  input  wire lft_pkg::slot_rpt_t rpt [lft_pkg::CacheEntries],
  output lft_pkg::slot_ctl_t      ctl [lft_pkg::CacheEntries],
  output lft_pkg::rsp_t           rsp
);
  import lft_pkg::*;

  logic [IdxW-1:0]         order      [CacheEntries];
  logic [IdxW-1:0]         order_next [CacheEntries];
  logic [CacheEntries-1:0] valid_vec;
  logic [CacheEntries-1:0] hit_vec;
  logic [CacheEntries-1:0] pos_valid;
  logic [CacheEntries-1:0] pos_hit;
  logic [CacheEntries-1:0] fill_oh;
  logic [CacheEntries-1:0] move_oh;
  logic [CacheEntries-1:0] before_move;
  logic                    any_hit;
  logic                    found;
  logic [1:0]              status_or;
  logic                    is_check;
  logic                    is_inc;
  logic                    is_reset;

  always_comb begin
    for (int s = 0; s < CacheEntries; s++) begin
      valid_vec[s] = rpt[s].valid;
      hit_vec[s]   = rpt[s].hit;
    end
    any_hit = |hit_vec;

    // valid slots sit at the front of the order, so the first empty position is the free one
    found = 1'b0;
    for (int p = 0; p < CacheEntries; p++) begin
      pos_valid[p] = valid_vec[order[p]];
      pos_hit[p]   = hit_vec[order[p]];
      fill_oh[p]   = !found && !pos_valid[p];
      if (!pos_valid[p]) found = 1'b1;
    end
    if (!found) fill_oh[CacheEntries-1] = 1'b1;

    move_oh = any_hit ? pos_hit : fill_oh;

    // move-to-front: positions up to the moved one shift back by one
    order_next[0] = '0;
    for (int p = 0; p < CacheEntries; p++) begin
      if (move_oh[p]) order_next[0] = order_next[0] | order[p];
    end
    before_move[0] = 1'b1;
    for (int q = 1; q < CacheEntries; q++) begin
      before_move[q] = before_move[q-1] && !move_oh[q-1];
      order_next[q]  = before_move[q] ? order[q-1] : order[q];
    end
  end

  always_comb begin
    is_check = fire && (cmd == CMD_CHECK);
    is_inc   = fire && (cmd == CMD_INC) && !count_suppress;
    is_reset = fire && (cmd == CMD_RESET);
    for (int s = 0; s < CacheEntries; s++) begin
      ctl[s].fill  = is_check && !any_hit && (order_next[0] == IdxW'(s));
      ctl[s].bump  = is_inc && valid_vec[s] && (order[0] == IdxW'(s));
      ctl[s].clear = is_reset && valid_vec[s] && (order[0] == IdxW'(s));
    end
  end

  always_comb begin
    status_or = STATUS_OK;
    for (int s = 0; s < CacheEntries; s++) begin
      if (hit_vec[s]) status_or = status_or | rpt[s].status;
    end
    rsp.hit    = (cmd == CMD_CHECK) && any_hit;
    rsp.status = rsp.hit ? status_or : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < CacheEntries; p++) order[p] <= IdxW'(p);
    end else if (is_check) begin
      order <= order_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/login_failure_lru_throttle.sv @@
// login_failure_lru_throttle: top level, request register, result register, config
// a request waits in the request register; its lookup and cache update run as it moves to the result register
// throughput: one request per cycle when neither channel stalls; a full, stalled result register holds the request
// reset (synchronous, rst high): cache empty, recency order 0..n-1, config at defaults
// depends on lft_pkg, lft_slot and lft_recency
`default_nettype none

module login_failure_lru_throttle (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire lft_pkg::req_t                 req,
  // result channel
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output lft_pkg::rsp_t                      rsp,
  // configuration writes
  input  wire logic                          cfg_write,
  input  wire logic [lft_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [lft_pkg::CfgDataW-1:0]  cfg_data
);
  import lft_pkg::*;

  cfg_t      cfg;
  req_t      req_q;
  logic      req_q_valid;
  logic      advance;
  logic      fire;
  rsp_t      result;
  slot_rpt_t rpt [CacheEntries];
  slot_ctl_t ctl [CacheEntries];

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_threshold  <= RST_LOCKOUT_THRESHOLD;
      cfg.lockout_seconds    <= RST_LOCKOUT_SECONDS;
      cfg.short_wait_enable  <= RST_SHORT_WAIT_ENABLE;
      cfg.short_wait_seconds <= RST_SHORT_WAIT_SECONDS;
      cfg.count_suppress     <= RST_COUNT_SUPPRESS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOCKOUT_THRESHOLD:  cfg.lockout_threshold  <= cfg_data[3:0];
        CFG_LOCKOUT_SECONDS:    cfg.lockout_seconds    <= cfg_data;
        CFG_SHORT_WAIT_ENABLE:  cfg.short_wait_enable  <= cfg_data[0];
        CFG_SHORT_WAIT_SECONDS: cfg.short_wait_seconds <= cfg_data;
        CFG_COUNT_SUPPRESS:     cfg.count_suppress     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the held request moves on whenever the result register is free or being emptied
  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = req_q_valid && advance;
  assign req_stall = req_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  // request payload, no reset
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // one compare and window test per cache entry
  for (genvar s = 0; s < CacheEntries; s++) begin : g_slot
    lft_slot u_slot (
      .clk (clk),
      .rst (rst),
      .req (req_q),
      .cfg (cfg),
      .ctl (ctl[s]),
      .rpt (rpt[s])
    );
  end

  // recency order, victim choice and result selection
  lft_recency u_recency (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .cmd            (req_q.cmd),
    .count_suppress (cfg.count_suppress),
    .rpt            (rpt),
    .ctl            (ctl),
    .rsp            (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= req_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_login_failure_lru_throttle.sv @@
// testbench for login_failure_lru_throttle: directed table then randomised policy phases
// each result is checked against its pinned table verdict or an in-bench model of the lru login cache
// depends on rtl/lft_pkg.sv and rtl/login_failure_lru_throttle.sv
module tb_login_failure_lru_throttle;
  timeunit 1ns;
  timeprecision 1ps;

  import lft_pkg::*;

  // bench limits
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 232;
  localparam int unsigned SAT_BURST = 260;
  localparam int unsigned POOL_SIZE = 5;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // register indexes past the last real register
  localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = CFG_COUNT_SUPPRESS + 3'd1;
  localparam int unsigned SPARE_COUNT = 3;

  typedef struct packed {
    logic [31:0] ip;
    logic [63:0] acct;
  } login_key_t;

  // one row of the directed table; verdict only used when pinned is set
  typedef struct packed {
    req_t item;
    logic pinned;
    rsp_t verdict;
  } step_t;

  localparam login_key_t KEY_A = {32'h0000_0000, 64'h0};
  localparam login_key_t KEY_B = {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
  localparam login_key_t KEY_C = {32'h8000_0000, 64'h8000_0000_0000_0000};
  localparam login_key_t KEY_D = {32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
  localparam login_key_t KEY_E = {32'hFFFF_FFFF, 64'h0};

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  login_failure_lru_throttle u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model of the cache: slot contents, recency list (position 0 most recent), policy
  logic        slot_used [CacheEntries];
  logic [31:0] slot_addr [CacheEntries];
  logic [63:0] slot_acct [CacheEntries];
  logic [7:0]  slot_fails[CacheEntries];
  logic [31:0] slot_stamp[CacheEntries];
  int          lru_order [CacheEntries];
  cfg_t        policy;

  // verdicts still owed by the block, oldest first
  rsp_t pending_verdicts[$];
  rsp_t oldest;
  step_t directed_steps[$];
  login_key_t key_pool[POOL_SIZE];

  logic [31:0] clock_now;
  logic calm;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned hits_seen;
  int unsigned lockouts_seen;
  int unsigned short_waits_seen;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wrapping time test: a stamp in the future always counts as inside the window
  function automatic logic in_window(input logic [31:0] t_now, input logic [31:0] t_stamp,
                                     input logic [15:0] span);
    logic signed [31:0] lag;
    lag = $signed(t_now - t_stamp);
    return (lag < 0) || (lag <= $signed({16'd0, span}));
  endfunction

  // move the slot held at recency position pos to the front
  function automatic void promote(input int pos);
    int s;
    s = lru_order[pos];
    for (int p = pos; p > 0; p--) lru_order[p] = lru_order[p - 1];
    lru_order[0] = s;
  endfunction

  // verdict for one request, updating the cache model as the block would
  function automatic rsp_t predict_verdict(input req_t r);
    rsp_t v;
    int n_used;
    int hit_pos;
    int s;
    v.status = STATUS_OK;
    v.hit = 1'b0;
    n_used = 0;
    hit_pos = -1;
    for (int i = 0; i < CacheEntries; i++) if (slot_used[i]) n_used++;
    case (r.cmd)
      CMD_CHECK: begin
        for (int p = 0; p < n_used; p++) begin
          s = lru_order[p];
          if (hit_pos < 0 && slot_addr[s] == r.client_ip && slot_acct[s] == r.account_key)
            hit_pos = p;
        end
        if (hit_pos >= 0) begin
          s = lru_order[hit_pos];
          v.hit = 1'b1;
          if (slot_fails[s] >= policy.lockout_threshold) begin
            if (in_window(r.now_seconds, slot_stamp[s], policy.lockout_seconds))
              v.status = STATUS_LOCK;
          end else if (slot_fails[s] != 8'd0 && policy.short_wait_enable) begin
            if (in_window(r.now_seconds, slot_stamp[s], policy.short_wait_seconds))
              v.status = STATUS_SHORT;
          end
          promote(hit_pos);
        end else begin
          // free slot if any, else the least recent one is recycled
          hit_pos = (n_used < CacheEntries) ? n_used : CacheEntries - 1;
          s = lru_order[hit_pos];
          slot_used[s] = 1'b1;
          slot_addr[s] = r.client_ip;
          slot_acct[s] = r.account_key;
          slot_fails[s] = 8'd0;
          slot_stamp[s] = r.now_seconds;
          promote(hit_pos);
        end
      end
      CMD_INC: begin
        s = lru_order[0];
        if (slot_used[s] && !policy.count_suppress) begin
          if (slot_fails[s] != FAIL_MAX) slot_fails[s] = slot_fails[s] + 8'd1;
          slot_stamp[s] = r.now_seconds;
        end
      end
      CMD_RESET: begin
        s = lru_order[0];
        if (slot_used[s]) begin
          slot_fails[s] = 8'd0;
          slot_stamp[s] = r.now_seconds;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic req_t make_req(input logic [1:0] c, input login_key_t k,
                                    input logic [31:0] t);
    return {c, k.ip, k.acct, t};
  endfunction

  function automatic login_key_t random_key();
    return {$urandom, $urandom, $urandom};
  endfunction

  // mostly small steps forward, now and then a big jump or a stamp from the past
  function automatic logic [31:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) clock_now = clock_now + $urandom_range(0, 3);
    else if (r < 75) clock_now = clock_now + $urandom_range(0, 20);
    else if (r < 88) clock_now = clock_now + $urandom_range(0, 200);
    else if (r < 94) clock_now = clock_now + $urandom_range(0, 2000);
    else if (r < 95) clock_now = $urandom;
    else return clock_now - $urandom_range(1, 60);
    return clock_now;
  endfunction

  // idle length: mostly from the shortest range, a few long stretches
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // one request transfer; the expectation is queued at the edge that accepts it
  task automatic issue(input req_t r, input logic pinned = 1'b0,
                       input rsp_t pinned_verdict = '0);
    int unsigned gap;
    rsp_t v;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_idle();
    if (gap != 0) begin
      @(negedge clk) req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    v = predict_verdict(r);
    pending_verdicts.push_back(pinned ? pinned_verdict : v);
    items_sent++;
  endtask

  task automatic add_step(input logic [1:0] c, input login_key_t k, input logic [31:0] t,
                          input logic pinned, input rsp_t v);
    directed_steps.push_back({make_req(c, k, t), pinned, v});
  endtask

  // hold the sender off until every owed verdict has come back
  task automatic settle();
    @(negedge clk) req_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    // the model takes only the low bits of the threshold, enable and suppress registers, as the block does
    case (idx)
      CFG_LOCKOUT_THRESHOLD:  policy.lockout_threshold = val[3:0];
      CFG_LOCKOUT_SECONDS:    policy.lockout_seconds = val;
      CFG_SHORT_WAIT_ENABLE:  policy.short_wait_enable = val[0];
      CFG_SHORT_WAIT_SECONDS: policy.short_wait_seconds = val;
      CFG_COUNT_SUPPRESS:     policy.count_suppress = val[0];
      default: ;
    endcase
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  task automatic program_policy(input logic [15:0] thr, input logic [15:0] lock_s,
                                input logic [15:0] en, input logic [15:0] short_s,
                                input logic [15:0] sup);
    write_reg(CFG_LOCKOUT_THRESHOLD, thr);
    write_reg(CFG_LOCKOUT_SECONDS, lock_s);
    write_reg(CFG_SHORT_WAIT_ENABLE, en);
    write_reg(CFG_SHORT_WAIT_SECONDS, short_s);
    write_reg(CFG_COUNT_SUPPRESS, sup);
  endtask

  // response stall: open runs of random length, then a stall of random length if not calm
  initial begin : stall_gen
    int unsigned len;
    rsp_stall = 1'b0;
    forever begin
      len = $urandom_range(1, 12);
      repeat (len) @(negedge clk);
      if (!calm) begin
        len = pick_idle();
        @(negedge clk) rsp_stall <= 1'b1;
        repeat (len - 1) @(negedge clk);
        @(negedge clk) rsp_stall <= 1'b0;
      end
    end
  end

  // result checker: each transfer against the oldest owed verdict
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing owed, status %0d hit %0d",
                 $time, rsp.status, rsp.hit);
      end else begin
        oldest = pending_verdicts.pop_front();
        results_checked++;
        if (rsp.status !== oldest.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, oldest.status, rsp.status);
        end
        if (rsp.hit !== oldest.hit) begin
          mismatches++;
          $display("%0t: hit mismatch, expected %0d, got %0d", $time, oldest.hit, rsp.hit);
        end
        if (oldest.hit) hits_seen++;
        if (oldest.status == STATUS_LOCK) lockouts_seen++;
        if (oldest.status == STATUS_SHORT) short_waits_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts still owed",
               $time, cycle_count, pending_verdicts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main
    rsp_t none;
    login_key_t k;
    logic [15:0] thr, lock_s, en, short_s, sup;
    int unsigned phase_start;
    int unsigned r;
    int unsigned n;

    // every input known from time zero
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    clock_now = '0;
    items_sent = 0;
    results_checked = 0;
    mismatches = 0;
    hits_seen = 0;
    lockouts_seen = 0;
    short_waits_seen = 0;
    cycle_count = 0;
    none = {STATUS_OK, 1'b0};

    // model after reset: empty cache, recency 0..n-1, policy at defaults
    for (int i = 0; i < CacheEntries; i++) begin
      slot_used[i] = 1'b0;
      slot_addr[i] = '0;
      slot_acct[i] = '0;
      slot_fails[i] = '0;
      slot_stamp[i] = '0;
      lru_order[i] = i;
    end
    policy.lockout_threshold = RST_LOCKOUT_THRESHOLD;
    policy.lockout_seconds = RST_LOCKOUT_SECONDS;
    policy.short_wait_enable = RST_SHORT_WAIT_ENABLE;
    policy.short_wait_seconds = RST_SHORT_WAIT_SECONDS;
    policy.count_suppress = RST_COUNT_SUPPRESS;

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed table, default policy: threshold 3, lockout 900 s, short wait 15 s
    // increment and reset on an empty cache do nothing
    add_step(CMD_INC, KEY_A, 32'd0, 1'b1, none);
    add_step(CMD_RESET, KEY_A, 32'd0, 1'b1, none);
    // unused command with every field bit set
    add_step(CMD_UNUSED, KEY_B, 32'hFFFF_FFFF, 1'b1, none);
    add_step(CMD_CHECK, KEY_A, 32'd100, 1'b1, none);
    add_step(CMD_CHECK, KEY_A, 32'd105, 1'b1, {STATUS_OK, 1'b1});
    add_step(CMD_INC, KEY_C, 32'd110, 1'b1, none);
    // one failure: short wait up to and including the window edge
    add_step(CMD_CHECK, KEY_A, 32'd125, 1'b1, {STATUS_SHORT, 1'b1});
    add_step(CMD_CHECK, KEY_A, 32'd126, 1'b1, {STATUS_OK, 1'b1});
    add_step(CMD_INC, KEY_B, 32'd130, 1'b1, none);
    add_step(CMD_INC, KEY_B, 32'd131, 1'b1, none);
    // threshold reached: long lockout to the window edge, then clear
    add_step(CMD_CHECK, KEY_A, 32'd1031, 1'b1, {STATUS_LOCK, 1'b1});
    add_step(CMD_CHECK, KEY_A, 32'd1032, 1'b1, {STATUS_OK, 1'b1});
    // a time before the last failure counts as inside the window
    add_step(CMD_CHECK, KEY_A, 32'd50, 1'b1, {STATUS_LOCK, 1'b1});
    add_step(CMD_CHECK, KEY_B, 32'hFFFF_FFFF, 1'b1, none);
    add_step(CMD_INC, KEY_A, 32'hFFFF_FFFF, 1'b1, none);
    // time wraps between the failure and the check
    add_step(CMD_CHECK, KEY_B, 32'd5, 1'b0, none);
    add_step(CMD_CHECK, KEY_C, 32'h8000_0000, 1'b1, none);
    // same address, other account: a miss that evicts the least recent entry
    add_step(CMD_CHECK, KEY_D, 32'd200, 1'b1, none);
    add_step(CMD_CHECK, KEY_E, 32'd201, 1'b0, none);
    add_step(CMD_CHECK, KEY_A, 32'd210, 1'b1, none);
    add_step(CMD_RESET, KEY_B, 32'd220, 1'b1, none);
    add_step(CMD_INC, KEY_C, 32'd221, 1'b1, none);
    add_step(CMD_CHECK, KEY_A, 32'd222, 1'b0, none);
    for (int i = 0; i < directed_steps.size(); i++)
      issue(directed_steps[i].item, directed_steps[i].pinned, directed_steps[i].verdict);

    // random phases, each under its own policy
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          // defaults written back explicitly
          thr = 16'd3; lock_s = 16'd900; en = 16'd1; short_s = 16'd15; sup = 16'd0;
        end
        1: begin
          // threshold one, zero-length windows
          thr = 16'd1; lock_s = 16'd0; en = 16'd1; short_s = 16'd0; sup = 16'd0;
        end
        2: begin
          // top of every range but suppress; the threshold keeps only its low four bits
          thr = 16'hFFFF; lock_s = 16'hFFFF; en = 16'hFFFF; short_s = 16'hFFFF; sup = 16'd0;
        end
        3: begin
          // threshold zero, short waits off, increments suppressed
          thr = 16'hFFF0; lock_s = 16'd30; en = 16'hFFFE; short_s = 16'd10; sup = 16'd1;
        end
        4: begin
          thr = 16'd2; lock_s = 16'd60; en = 16'd1; short_s = 16'd8; sup = 16'd0;
        end
        default: begin
          thr = 16'($urandom);
          lock_s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
          en = 16'($urandom);
          short_s = 16'($urandom_range(0, 40));
          sup = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0000;
        end
      endcase
      // writes to the spare indexes must leave the policy alone
      if (ph == 5)
        for (int i = 0; i < SPARE_COUNT; i++)
          write_reg(CfgIdxW'(CFG_SPARE_FIRST + i), 16'($urandom));
      program_policy(thr, lock_s, en, short_s, sup);
      repeat (DRAIN_CYCLES) @(posedge clk);

      calm = (ph == 3);
      clock_now = (ph == 2) ? 32'hFFFF_FF80 : $urandom;
      // pool keys share address or account so both halves of the compare matter
      key_pool[0] = random_key();
      key_pool[1] = {key_pool[0].ip, 64'($urandom) << 32 | 64'($urandom)};
      key_pool[2] = {32'($urandom), key_pool[0].acct};
      for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = random_key();
      phase_start = items_sent;

      // failure counter driven to saturation, then checked under the top threshold
      if (ph == 2) begin
        issue(make_req(CMD_CHECK, key_pool[0], next_time()));
        repeat (SAT_BURST) issue(make_req(CMD_INC, random_key(), next_time()));
        issue(make_req(CMD_CHECK, key_pool[0], next_time()));
      end

      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 55) begin
          // a login attempt: look up, fail a few times, come back
          issue(make_req(CMD_CHECK, k, next_time()));
          n = $urandom_range(0, 4);
          repeat (n) issue(make_req(CMD_INC, random_key(), next_time()));
          if ($urandom_range(0, 5) == 0) issue(make_req(CMD_RESET, random_key(), next_time()));
          issue(make_req(CMD_CHECK, k, next_time()));
        end else if (r < 80) begin
          n = $urandom_range(0, 9);
          if (n < 5) issue(make_req(CMD_CHECK, k, next_time()));
          else if (n < 8) issue(make_req(CMD_INC, random_key(), next_time()));
          else if (n < 9) issue(make_req(CMD_RESET, random_key(), next_time()));
          else issue(make_req(CMD_UNUSED, random_key(), next_time()));
        end else if (r < 92) begin
          // unseen source: forces fills and evictions
          issue(make_req(CMD_CHECK, random_key(), next_time()));
        end else if (r < 97) begin
          issue(make_req(($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_RESET,
                         random_key(), $urandom));
        end else begin
          // pause the sender until the block has nothing left in flight
          settle();
        end
      end
      calm = 1'b0;
    end

    settle();
    $display("%0d requests sent, %0d verdicts checked over %0d policy settings",
             items_sent, results_checked, PHASES + 1);
    $display("%0d hits, %0d long lockouts, %0d short waits, %0d mismatches",
             hits_seen, lockouts_seen, short_waits_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
